>>> rtl/mlss_pkg.sv
// Shared constants, types and helpers for the max loading subset search block.
`default_nettype none
package mlss_pkg;

  localparam int MAX_WEIGHTS = 16;
  localparam int WEIGHT_W    = 16;
  localparam int LOAD_W      = 24;
  localparam int SUM_W       = LOAD_W + 1;
  localparam int CNT_W       = $clog2(MAX_WEIGHTS + 1);
  localparam int IDX_W       = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
  localparam int STEP_W      = MAX_WEIGHTS + 1;

  // Register map, word index = paddr / 4.
  localparam int PADDR_W = 4;
  typedef enum logic [1:0] {
    REG_CAPACITY     = 2'd0,
    REG_BASE_LOAD    = 2'd1,
    REG_INITIAL_BEST = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } search_state_t;

  // Set info seen by an incoming word that closes the set.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             too_many;
  } store_info_t;

  typedef struct packed {
    logic busy;
    logic done;
  } search_stat_t;

  // Index of the lowest set bit among the low MAX_WEIGHTS bits.
  function automatic logic [IDX_W-1:0] low_bit_idx(input logic [STEP_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_WEIGHTS - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

>>> rtl/max_loading_subset_search.sv
// Top level: APB registers, weight store, subset search and result register.
//
//  channel   dir  handshake                  payload
//  s_*       in   s_tvalid / s_tready        s_tdata = weight, s_tlast = last_weight
//  m_*       out  m_tvalid / m_tready        m_tdata = best_load, m_tuser = too_many
//  apb       in   psel, penable, pready=1    capacity, base_load, initial_best
//
// A weight word is taken in any cycle in which the input is ready. The word
// flagged tlast starts the search: the shared adder/comparer walks all 2^n
// subsets of the n stored weights in Gray order, one subset per cycle, then
// hands the result to the output register. Input is not ready during the
// search or until its result moves on; weights are taken while a result
// still waits in the output register. Reset (rst, synchronous) empties the
// weight set, clears the configuration registers and drops the output valid.
`default_nettype none
module max_loading_subset_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // weight stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [15:0]                   s_tdata,   // [15:0] weight
  input  wire logic                          s_tlast,   // last_weight
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [23:0]                   m_tdata,   // [23:0] best_load
  output logic                               m_tuser,   // [0] too_many
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlss_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import mlss_pkg::*;

  logic [LOAD_W-1:0] capacity;
  logic [LOAD_W-1:0] base_load;
  logic [LOAD_W-1:0] initial_best;
  reg_idx_t          reg_sel;
  logic              cfg_wr;

  logic              in_acc;
  store_info_t       info;
  logic [IDX_W-1:0]  rd_idx;
  logic [WEIGHT_W-1:0] rd_data;
  logic [LOAD_W-1:0] result;
  search_stat_t      stat;
  logic              start;
  logic              ack;
  logic              too_many_hold;

  // --- configuration registers ---
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= '0;
      base_load    <= '0;
      initial_best <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CAPACITY:     capacity     <= pwdata[LOAD_W-1:0];
        REG_BASE_LOAD:    base_load    <= pwdata[LOAD_W-1:0];
        REG_INITIAL_BEST: initial_best <= pwdata[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAPACITY:     prdata = {8'd0, capacity};
      REG_BASE_LOAD:    prdata = {8'd0, base_load};
      REG_INITIAL_BEST: prdata = {8'd0, initial_best};
      default:          prdata = '0;
    endcase
  end

  // --- input side ---
  assign s_tready = !stat.busy;
  assign in_acc   = s_tvalid && s_tready;
  assign start    = in_acc && s_tlast;

  mlss_weight_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (in_acc),
    .weight  (s_tdata),
    .last    (s_tlast),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .info    (info)
  );

  // overflow flag of the closing set rides along with the search
  always_ff @(posedge clk) begin
    if (start) too_many_hold <= info.too_many;
  end

  mlss_search u_search (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .ack          (ack),
    .n_in         (info.n),
    .capacity     (capacity),
    .base_load    (base_load),
    .initial_best (initial_best),
    .rd_idx       (rd_idx),
    .rd_data      (rd_data),
    .result       (result),
    .stat         (stat)
  );

  // --- output register: result moves in once the previous word is gone ---
  assign ack = stat.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      m_tdata <= result;
      m_tuser <= too_many_hold;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mlss_weight_store.sv
// Weight register file with fill count and overflow flag.
`default_nettype none
module mlss_weight_store (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr,
  input  wire logic [mlss_pkg::WEIGHT_W-1:0]   weight,
  input  wire logic                            last,
  input  wire logic [mlss_pkg::IDX_W-1:0]      rd_idx,
  output logic      [mlss_pkg::WEIGHT_W-1:0]   rd_data,
  output mlss_pkg::store_info_t                info
);
  import mlss_pkg::*;

  logic [WEIGHT_W-1:0] weights [MAX_WEIGHTS];
  logic [CNT_W-1:0]    count;
  logic                overflow;
  logic                full;

  assign full          = (count == CNT_W'(MAX_WEIGHTS));
  assign info.n        = full ? count : count + CNT_W'(1);
  assign info.too_many = overflow | full;
  assign rd_data       = weights[rd_idx];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      weights[count[IDX_W-1:0]] <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (wr) begin
      if (last) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/mlss_search.sv
// Gray-code subset walk: one add or subtract and the fit and best compares per cycle.
`default_nettype none
module mlss_search (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            ack,
  input  wire logic [mlss_pkg::CNT_W-1:0]      n_in,
  input  wire logic [mlss_pkg::LOAD_W-1:0]     capacity,
  input  wire logic [mlss_pkg::LOAD_W-1:0]     base_load,
  input  wire logic [mlss_pkg::LOAD_W-1:0]     initial_best,
  output logic      [mlss_pkg::IDX_W-1:0]      rd_idx,
  input  wire logic [mlss_pkg::WEIGHT_W-1:0]   rd_data,
  output logic      [mlss_pkg::LOAD_W-1:0]     result,
  output mlss_pkg::search_stat_t               stat
);
  import mlss_pkg::*;

  search_state_t        state, state_next;
  logic [SUM_W-1:0]     load;
  logic [LOAD_W-1:0]    best;
  logic [MAX_WEIGHTS-1:0] gray;
  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     n;
  logic                 cand_ok;
  logic                 last_cand;

  assign rd_idx    = low_bit_idx(step);
  // Empty subset always counts; otherwise the load must fit.
  assign cand_ok   = (gray == '0) || (load <= {1'b0, capacity});
  assign last_cand = step[n];
  assign result    = best;
  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_HOLD);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_RUN;
      S_RUN:  if (last_cand) state_next = S_HOLD;
      S_HOLD: if (ack) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      load <= {1'b0, base_load};
      best <= initial_best;
      gray <= '0;
      step <= STEP_W'(1);
      n    <= n_in;
    end else if (state == S_RUN) begin
      if (cand_ok && load > {1'b0, best}) begin
        best <= load[LOAD_W-1:0];
      end
      if (!last_cand) begin
        gray[rd_idx] <= ~gray[rd_idx];
        if (gray[rd_idx]) load <= load - SUM_W'(rd_data);
        else              load <= load + SUM_W'(rd_data);
        step <= step + STEP_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> verif/max_loading_subset_search_tb.sv
// Self-checking testbench for max_loading_subset_search: weight stream in, best load out.
module max_loading_subset_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlss_pkg::*;

  // The slowest sane run (at most BIG_SETS_MAX 2^16-subset searches dominate)
  // stays well under this limit, which leaves a wide margin.
  localparam int         LIMIT_CYCLES = 3_000_000;
  localparam int         RANDOM_WORDS = 1700;
  localparam int         MAX_SHOWN    = 10;
  localparam int         BIG_SETS_MAX = 4;
  localparam logic [1:0] REG_SPARE    = 2'd3;  // unmapped slot, writes must vanish

  typedef struct packed {
    logic [LOAD_W-1:0] load;
    logic              too_many;
  } load_result_t;

  // One directed word; new_cfg means drain and reprogram before sending it.
  typedef struct {
    bit                  new_cfg;
    logic [LOAD_W-1:0]   cap;
    logic [LOAD_W-1:0]   base;
    logic [LOAD_W-1:0]   best0;
    logic [WEIGHT_W-1:0] weight;
    bit                  last;
    bit                  typed;  // want holds a hand-derived result
    load_result_t        want;
  } plan_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WEIGHT_W-1:0]  s_tdata  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [LOAD_W-1:0]    m_tdata;
  logic                 m_tuser;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [31:0]          pwdata   = '0;
  logic [31:0]          prdata;
  logic                 pready;

  max_loading_subset_search dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [15:0] weight
    .s_tlast (s_tlast),   // last_weight
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // [23:0] best_load
    .m_tuser (m_tuser),   // [0] too_many
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the weight set and the registers.
  // ---------------------------------------------------------------------
  logic [WEIGHT_W-1:0] held_weights [MAX_WEIGHTS];
  int                  held_count   = 0;
  bit                  dropped_any  = 1'b0;
  logic [LOAD_W-1:0]   cfg_capacity = '0;
  logic [LOAD_W-1:0]   cfg_base     = '0;
  logic [LOAD_W-1:0]   cfg_best0    = '0;
  load_result_t        pending_loads [$];  // best loads still owed by the block

  plan_row_t           plan [$];

  // sender pacing
  bit                  bursty     = 1'b0;
  int                  burst_left = 0;

  // receiver stall pattern
  int unsigned         cycle_no  = 0;
  int                  stall_pct = 0;

  int unsigned         mismatches      = 0;
  int unsigned         words_total     = 0;
  int unsigned         sets_total      = 0;
  int unsigned         overflow_sets   = 0;
  int unsigned         results_checked = 0;
  int unsigned         settings_used   = 0;
  int unsigned         big_sets        = 0;
  load_result_t        head;

  function automatic void note_mismatch(string what, logic [31:0] exp, logic [31:0] act);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("MISMATCH %s: expected %h, got %h", what, exp, act);
  endfunction

  // Heaviest load base + subset sum within capacity; the empty subset
  // always counts, so base wins even above capacity. Never below best0.
  function automatic logic [LOAD_W-1:0] best_fit_load();
    longint unsigned top;
    longint unsigned sum;
    top = 64'(cfg_best0);
    if (64'(cfg_base) > top) top = 64'(cfg_base);
    for (int m = 1; m < (1 << held_count); m++) begin
      sum = 64'(cfg_base);
      for (int k = 0; k < held_count; k++)
        if (m[k]) sum += 64'(held_weights[k]);
      if (sum <= 64'(cfg_capacity) && sum > top) top = sum;
    end
    return top[LOAD_W-1:0];
  endfunction

  function automatic void add_row(bit c, logic [LOAD_W-1:0] cap, logic [LOAD_W-1:0] base,
                                  logic [LOAD_W-1:0] best0, logic [WEIGHT_W-1:0] w,
                                  bit last, bit typed, logic [LOAD_W-1:0] load, bit many);
    plan_row_t r;
    r.new_cfg = c;
    r.cap = cap;
    r.base = base;
    r.best0 = best0;
    r.weight = w;
    r.last = last;
    r.typed = typed;
    r.want.load = load;
    r.want.too_many = many;
    plan.push_back(r);
  endfunction

  // One weight word through the handshake, then into the predictor.
  // Gaps between bursts put noise on tdata/tlast while tvalid is low.
  task automatic send_word(input logic [WEIGHT_W-1:0] w, input bit last,
                           input bit typed, input load_result_t want);
    load_result_t got;
    if (bursty && burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= WEIGHT_W'($urandom);
      s_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) burst_left--;
    words_total++;
    // store, or drop once the set is full
    if (held_count < MAX_WEIGHTS) begin
      held_weights[held_count] = w;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (last) begin
      got.load     = best_fit_load();
      got.too_many = dropped_any;
      if (dropped_any) overflow_sets++;
      pending_loads.push_back(typed ? want : got);
      sets_total++;
      held_count  = 0;
      dropped_any = 1'b0;
    end
  endtask

  // Sender holds off until every owed result is out, then a short settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB setup + access; leaves psel up so accesses run back to back.
  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] data,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  // Program all three registers (junk in the unused upper bits), hit the
  // unmapped slot, then read everything back.
  task automatic set_config(input logic [LOAD_W-1:0] cap, input logic [LOAD_W-1:0] base,
                            input logic [LOAD_W-1:0] best0);
    logic [31:0]       rd;
    reg_idx_t          regs [3];
    logic [LOAD_W-1:0] vals [3];
    regs = '{REG_CAPACITY, REG_BASE_LOAD, REG_INITIAL_BEST};
    vals = '{cap, base, best0};
    for (int i = 0; i < 3; i++)
      apb_access(regs[i], 1'b1, {8'($urandom), vals[i]}, rd);
    apb_access(REG_SPARE, 1'b1, $urandom, rd);
    for (int i = 0; i < 3; i++) begin
      apb_access(regs[i], 1'b0, 32'h0, rd);
      if (rd[LOAD_W-1:0] !== vals[i]) note_mismatch("register readback", 32'(vals[i]), rd);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_capacity = cap;
    cfg_base     = base;
    cfg_best0    = best0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: check each accepted word against the oldest expectation,
  // and drive tready from a randomly redrawn stall rate.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_no++;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_loads.size() == 0) begin
        note_mismatch("unexpected result word, best_load", 32'h0, 32'(m_tdata));
      end else begin
        head = pending_loads.pop_front();
        results_checked++;
        if (m_tdata !== head.load)
          note_mismatch("best_load", 32'(head.load), 32'(m_tdata));
        if (m_tuser !== head.too_many)
          note_mismatch("too_many", 32'(head.too_many), 32'(m_tuser));
      end
    end
    if (cycle_no % 300 == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 20;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int unsigned         random_words;
    int                  n;
    int                  mode;
    logic [WEIGHT_W-1:0] w;
    logic [LOAD_W-1:0]   cap;
    logic [LOAD_W-1:0]   base;
    logic [LOAD_W-1:0]   best0;
    longint unsigned     wide;
    load_result_t        none;

    random_words = 0;
    none = '0;

    // Directed rows. Registers are still at reset (all zero) for the first two.
    add_row(0, 0, 0, 0, 16'h0000, 1, 1, 24'h000000, 0);  // zero weight, zero capacity
    add_row(0, 0, 0, 0, 16'hFFFF, 1, 1, 24'h000000, 0);  // heaviest weight cannot fit
    // capacity wide open: both heaviest weights go in
    add_row(1, 24'hFFFFFF, 0, 0, 16'hFFFF, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 16'hFFFF, 1, 1, 24'h01FFFE, 0);
    // base already over capacity: base itself is the answer
    add_row(1, 24'h000100, 24'h000200, 0, 16'h0001, 1, 1, 24'h000200, 0);
    // small knapsack, initial best just under the optimum
    add_row(1, 24'h000050, 24'h000010, 24'h00003F, 16'h0020, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 16'h0030, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 16'h0025, 1, 0, 0, 0);
    // every register at full scale
    add_row(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h1234, 1, 1, 24'hFFFFFF, 0);
    // 16 weights fill capacity exactly; the flagged 17th is dropped
    for (int k = 0; k < MAX_WEIGHTS; k++)
      add_row(k == 0, 24'h008000, 0, 0, 16'h0800, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 16'hFFFF, 1, 1, 24'h008000, 1);
    // the next set must start clean: no stale weights, no stale overflow
    add_row(0, 0, 0, 0, 16'h0003, 1, 1, 24'h000003, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].new_cfg) begin
        wait_idle();
        set_config(plan[i].cap, plan[i].base, plan[i].best0);
      end
      send_word(plan[i].weight, plan[i].last, plan[i].typed, plan[i].want);
    end

    // Random phases: fresh settings, then a run of complete weight sets.
    while (random_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 4))
        0:       base = '0;
        1:       base = '1;
        2:       base = LOAD_W'($urandom);
        default: base = LOAD_W'($urandom_range(0, 'h2000));
      endcase
      case ($urandom_range(0, 5))
        0:       cap = '0;
        1:       cap = '1;
        2:       cap = LOAD_W'($urandom);
        default: begin
          wide = 64'(base) + 64'($urandom_range(0, 'h30000));
          cap  = (wide > 'hFFFFFF) ? '1 : wide[LOAD_W-1:0];
        end
      endcase
      case ($urandom_range(0, 4))
        0:       best0 = '0;
        1:       best0 = '1;
        2:       best0 = LOAD_W'($urandom);
        default: best0 = LOAD_W'($urandom_range(0, 'h8000));
      endcase
      wait_idle();
      set_config(cap, base, best0);
      bursty = ($urandom_range(0, 3) != 0);

      repeat ($urandom_range(3, 30)) begin
        // the search walks 2^n subsets, so full and overflowing sets stay rare
        if ($urandom_range(0, 99) == 0 && big_sets < BIG_SETS_MAX) begin
          n = (big_sets % 2 == 0) ? MAX_WEIGHTS : $urandom_range(MAX_WEIGHTS + 1, 20);
          big_sets++;
        end else if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 2);
        end else begin
          n = $urandom_range(1, 8);
        end
        mode = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
          case (mode)
            0:       w = WEIGHT_W'($urandom);
            1:       w = WEIGHT_W'($urandom_range(0, 255));
            2:       w = $urandom_range(0, 1) ? '1 : '0;
            default: w = WEIGHT_W'($urandom_range(0, 'h0FFF));
          endcase
          send_word(w, k == n - 1, 1'b0, none);
          random_words++;
        end
      end
    end

    // Drain, then give the block time to show any stray result.
    s_tvalid <= 1'b0;
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run: %0d weight words in %0d sets, %0d with dropped words, %0d big sets",
             words_total, sets_total, overflow_sets, big_sets);
    $display("Run: %0d results checked under %0d register settings, %0d mismatches",
             results_checked, settings_used, mismatches);
    if (mismatches == 0 && pending_loads.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
